// ===== hdl/rv32i_instruction_execute_unit_defines.svh =====
// ---------------------------------------------------------------------------
// RV32I execute unit assertion macros
// Concurrent check wrappers, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef RV32I_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
`define RV32I_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RVEX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("check failed");
`define RVEX_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error("never failed");
`else
`define RVEX_ASSERT(lbl, prop)
`define RVEX_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== hdl/rvex_pkg.sv =====
// ---------------------------------------------------------------------------
// RV32I execute unit package
// Operation codes, sizes and the execute result record.
// ---------------------------------------------------------------------------
package rvex_pkg;

  localparam int MemBytesDef = 4096;
  localparam int RegCount    = 32;
  localparam int RegAw       = $clog2(RegCount);
  localparam int Xlen        = 32;
  localparam int ImmW        = 21;
  localparam int OpW         = 6;

  typedef enum logic [OpW-1:0] {
    OP_LUI = 6'd0, OP_AUIPC = 6'd1, OP_JAL = 6'd2, OP_JALR = 6'd3,
    OP_ADDI = 6'd4, OP_SLTI = 6'd5, OP_SLTIU = 6'd6, OP_XORI = 6'd7,
    OP_ORI = 6'd8, OP_ANDI = 6'd9, OP_SLLI = 6'd10, OP_SRLI = 6'd11,
    OP_SRAI = 6'd12, OP_LB = 6'd13, OP_LH = 6'd14, OP_LW = 6'd15,
    OP_LBU = 6'd16, OP_LHU = 6'd17, OP_BEQ = 6'd18, OP_BNE = 6'd19,
    OP_BLT = 6'd20, OP_BGE = 6'd21, OP_BLTU = 6'd22, OP_BGEU = 6'd23,
    OP_SB = 6'd24, OP_SH = 6'd25, OP_SW = 6'd26, OP_ADD = 6'd27,
    OP_SUB = 6'd28, OP_SLL = 6'd29, OP_SLT = 6'd30, OP_SLTU = 6'd31,
    OP_XOR = 6'd32, OP_SRL = 6'd33, OP_SRA = 6'd34, OP_OR = 6'd35,
    OP_AND = 6'd36, OP_FENCE = 6'd37, OP_ECALL = 6'd38, OP_EBREAK = 6'd39
  } op_e;

  typedef struct packed {
    logic [Xlen-1:0] wv;
    logic            we;
    logic [Xlen-1:0] npc;
    logic            halt;
    logic            load;
    logic            store;
    logic [2:0]      nbytes;
    logic [Xlen-1:0] addr;
  } exec_t;

endpackage

// ===== hdl/rv32i_instruction_execute_unit.sv =====
// Path: execute then output registers, with a data memory stage between
// them for loads. Throughput: one word per cycle while the output is not
// stalled; a load holds the input while its data memory read completes and
// its register write lands. Reset: registers, pc and halt flag clear at
// once; a sweep clears the MEM_BYTES/4 data memory rows, taking no word.
// ---------------------------------------------------------------------------
// RV32I execute unit
// Register file, pc, byte data memory and halt flag around one execute stage.
// ---------------------------------------------------------------------------
`include "rv32i_instruction_execute_unit_defines.svh"

module rv32i_instruction_execute_unit #(
  parameter int MEM_BYTES = rvex_pkg::MemBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rvex_pkg::OpW-1:0]    mode_i,
  input  logic [rvex_pkg::RegAw-1:0]  dest_reg_i,
  input  logic [rvex_pkg::RegAw-1:0]  src_reg_a_i,
  input  logic [rvex_pkg::RegAw-1:0]  src_reg_b_i,
  input  logic signed [rvex_pkg::ImmW-1:0] imm_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rvex_pkg::Xlen-1:0]   next_pc_o,
  output logic                        write_enable_o,
  output logic [rvex_pkg::RegAw-1:0]  write_reg_o,
  output logic [rvex_pkg::Xlen-1:0]   write_value_o,
  output logic                        halted_o
);
  import rvex_pkg::*;

  localparam int MemAw = $clog2(MEM_BYTES);
  localparam int Rows  = MEM_BYTES / 4;
  localparam int RowAw = MemAw - 2;

  // control state
  logic clr_busy_q, clr_busy_d;
  logic [RowAw-1:0] clr_idx_q, clr_idx_d;
  logic x_valid_q, x_valid_d;
  logic m_valid_q, m_valid_d;
  logic halt_q, halt_d;
  logic [Xlen-1:0] pc_q, pc_d;
  logic [RegCount-1:0] rf_valid_q, rf_valid_d;
  logic out_valid_q, out_valid_d;

  // payload state
  logic [OpW-1:0]   x_mode_q;
  logic [RegAw-1:0] x_rd_q;
  logic [Xlen-1:0]  x_imm_q;
  logic             x_za_q, x_zb_q, x_fa_q, x_fb_q;
  logic [Xlen-1:0]  x_fval_q;
  logic [OpW-1:0]   m_mode_q;
  logic [RegAw-1:0] m_rd_q;
  logic [1:0]       m_off_q;
  logic [Xlen-1:0]  m_npc_q;
  logic [Xlen-1:0]  out_npc_q, out_npc_d;
  logic             out_we_q, out_we_d;
  logic [RegAw-1:0] out_rd_q, out_rd_d;
  logic [Xlen-1:0]  out_wv_q, out_wv_d;
  logic             out_halt_q, out_halt_d;

  logic in_acc, out_free, x_load, x_fire, x_to_m, m_fire;
  logic rf_we;
  logic [RegAw-1:0] rf_waddr;
  logic [Xlen-1:0]  rf_wdata;
  logic [Xlen-1:0]  rdata_a, rdata_b, op_a, op_b;
  exec_t res;
  logic [MemAw-1:0] addr_lo;
  logic [7:0]       bank_rdata [4];
  logic [Xlen-1:0]  ld_raw, ld_val;
  logic [1:0]       bsel [4];

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign x_load     = x_valid_q && !halt_q && res.load;
  assign x_to_m     = x_load;
  assign x_fire     = x_valid_q && !x_load && out_free;
  assign m_fire     = m_valid_q && out_free;
  assign in_stall_o = clr_busy_q || m_valid_q || (x_valid_q && !x_fire);
  assign in_acc     = in_valid_i && !in_stall_o;

  // register file write: execute stage or load write-back
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = x_rd_q;
    rf_wdata = res.wv;
    if (x_fire && !halt_q && res.we && (x_rd_q != '0)) begin
      rf_we = 1'b1;
    end else if (m_fire && (m_rd_q != '0)) begin
      rf_we    = 1'b1;
      rf_waddr = m_rd_q;
      rf_wdata = ld_val;
    end
  end

  rvex_ram #(.WIDTH(Xlen), .DEPTH(RegCount)) u_rf_a (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .re_i(in_acc), .raddr_i(src_reg_a_i), .rdata_o(rdata_a)
  );
  rvex_ram #(.WIDTH(Xlen), .DEPTH(RegCount)) u_rf_b (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .re_i(in_acc), .raddr_i(src_reg_b_i), .rdata_o(rdata_b)
  );

  // operands: forward a write made on the accept edge, zero unwritten entries
  assign op_a = x_fa_q ? x_fval_q : (x_za_q ? '0 : rdata_a);
  assign op_b = x_fb_q ? x_fval_q : (x_zb_q ? '0 : rdata_b);

  rvex_alu u_alu (
    .op_i(x_mode_q), .a_i(op_a), .b_i(op_b), .imm_i(x_imm_q), .pc_i(pc_q),
    .res_o(res)
  );

  // byte banks: bank k holds bytes whose address is k modulo four
  assign addr_lo = res.addr[MemAw-1:0];
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [1:0]       idx;
    logic [MemAw-1:0] baddr;
    logic             bwe;
    logic [RowAw-1:0] waddr;
    logic [7:0]       wdata;
    assign idx   = 2'(k) - addr_lo[1:0];
    assign baddr = addr_lo + MemAw'(idx);
    assign bwe   = clr_busy_q ||
                   (x_fire && !halt_q && res.store && ({1'b0, idx} < res.nbytes));
    assign waddr = clr_busy_q ? clr_idx_q : baddr[MemAw-1:2];
    assign wdata = clr_busy_q ? 8'd0 : 8'(op_b >> {idx, 3'b000});
    rvex_ram #(.WIDTH(8), .DEPTH(Rows)) u_mem (
      .clk_i, .we_i(bwe), .waddr_i(waddr), .wdata_i(wdata),
      .re_i(x_to_m), .raddr_i(baddr[MemAw-1:2]), .rdata_o(bank_rdata[k])
    );
  end

  // gather load bytes in address order and extend
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bsel[i] = m_off_q + 2'(i);
    end
    ld_raw = {bank_rdata[bsel[3]], bank_rdata[bsel[2]],
              bank_rdata[bsel[1]], bank_rdata[bsel[0]]};
    unique case (op_e'(m_mode_q)) inside
      OP_LB:   ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
      OP_LH:   ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
      OP_LBU:  ld_val = {24'd0, ld_raw[7:0]};
      OP_LHU:  ld_val = {16'd0, ld_raw[15:0]};
      default: ld_val = ld_raw;
    endcase
  end

  // next state
  always_comb begin
    clr_busy_d  = clr_busy_q;
    clr_idx_d   = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (clr_idx_q == RowAw'(Rows - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
    x_valid_d   = in_acc ? 1'b1 : ((x_fire || x_to_m) ? 1'b0 : x_valid_q);
    m_valid_d   = x_to_m ? 1'b1 : (m_fire ? 1'b0 : m_valid_q);
    halt_d      = halt_q;
    pc_d        = pc_q;
    if ((x_fire || x_to_m) && !halt_q) begin
      pc_d   = res.npc;
      halt_d = res.halt;
    end
    rf_valid_d  = rf_valid_q;
    if (rf_we) begin
      rf_valid_d[rf_waddr] = 1'b1;
    end
    out_valid_d = (x_fire || m_fire) ? 1'b1 : (out_free ? 1'b0 : out_valid_q);
    out_npc_d   = out_npc_q;
    out_we_d    = out_we_q;
    out_rd_d    = out_rd_q;
    out_wv_d    = out_wv_q;
    out_halt_d  = out_halt_q;
    if (x_fire) begin
      out_npc_d  = halt_q ? pc_q : res.npc;
      out_we_d   = !halt_q && res.we && (x_rd_q != '0);
      out_rd_d   = out_we_d ? x_rd_q : '0;
      out_wv_d   = out_we_d ? res.wv : '0;
      out_halt_d = halt_q || res.halt;
    end else if (m_fire) begin
      out_npc_d  = m_npc_q;
      out_we_d   = (m_rd_q != '0);
      out_rd_d   = m_rd_q;
      out_wv_d   = out_we_d ? ld_val : '0;
      out_halt_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      x_valid_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      halt_q      <= 1'b0;
      pc_q        <= '0;
      rf_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_idx_q   <= clr_idx_d;
      x_valid_q   <= x_valid_d;
      m_valid_q   <= m_valid_d;
      halt_q      <= halt_d;
      pc_q        <= pc_d;
      rf_valid_q  <= rf_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_mode_q <= mode_i;
      x_rd_q   <= dest_reg_i;
      x_imm_q  <= 32'(imm_value_i);
      x_za_q   <= (src_reg_a_i == '0) || !rf_valid_q[src_reg_a_i];
      x_zb_q   <= (src_reg_b_i == '0) || !rf_valid_q[src_reg_b_i];
      x_fa_q   <= rf_we && (rf_waddr == src_reg_a_i);
      x_fb_q   <= rf_we && (rf_waddr == src_reg_b_i);
      x_fval_q <= rf_wdata;
    end
    if (x_to_m) begin
      m_mode_q <= x_mode_q;
      m_rd_q   <= x_rd_q;
      m_off_q  <= addr_lo[1:0];
      m_npc_q  <= res.npc;
    end
    out_npc_q  <= out_npc_d;
    out_we_q   <= out_we_d;
    out_rd_q   <= out_rd_d;
    out_wv_q   <= out_wv_d;
    out_halt_q <= out_halt_d;
  end

  assign out_valid_o    = out_valid_q;
  assign next_pc_o      = out_npc_q;
  assign write_enable_o = out_we_q;
  assign write_reg_o    = out_rd_q;
  assign write_value_o  = out_wv_q;
  assign halted_o       = out_halt_q;

  // checks
  `RVEX_ASSERT_NEVER(a_no_accept_in_clear, clr_busy_q && in_acc)
  `RVEX_ASSERT_NEVER(a_x_and_m_busy, x_valid_q && m_valid_q)
  `RVEX_ASSERT_NEVER(a_x0_written, rf_we && (rf_waddr == '0))
  `RVEX_ASSERT(a_halt_sticks, halt_q |=> halt_q)
  `RVEX_ASSERT(a_load_drains, (m_valid_q && out_free) |=> !m_valid_q)

endmodule

// ===== hdl/rvex_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ---------------------------------------------------------------------------
module rvex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rvex_alu.sv =====
// ---------------------------------------------------------------------------
// RV32I execute datapath
// Computes the write value, next pc and memory request for one instruction.
// ---------------------------------------------------------------------------
module rvex_alu (
  input  logic [rvex_pkg::OpW-1:0]  op_i,
  input  logic [rvex_pkg::Xlen-1:0] a_i,
  input  logic [rvex_pkg::Xlen-1:0] b_i,
  input  logic [rvex_pkg::Xlen-1:0] imm_i,
  input  logic [rvex_pkg::Xlen-1:0] pc_i,
  output rvex_pkg::exec_t           res_o
);
  import rvex_pkg::*;

  exec_t           r;
  logic            take;
  logic [Xlen-1:0] pc4;

  always_comb begin
    r        = '0;
    take     = 1'b0;
    pc4      = pc_i + 32'd4;
    r.npc    = pc4;
    r.addr   = a_i + imm_i;
    unique case (op_e'(op_i)) inside
      OP_LUI:    begin r.wv = imm_i << 12; r.we = 1'b1; end
      OP_AUIPC:  begin r.wv = (imm_i << 12) + pc_i; r.we = 1'b1; end
      OP_JAL:    begin r.wv = pc4; r.we = 1'b1; take = 1'b1; end
      OP_JALR:   begin
        r.wv  = pc4;
        r.we  = 1'b1;
        r.npc = {r.addr[Xlen-1:1], 1'b0};
      end
      OP_ADDI:   begin r.wv = r.addr; r.we = 1'b1; end
      OP_SLTI:   begin r.wv = {31'd0, $signed(a_i) < $signed(imm_i)}; r.we = 1'b1; end
      OP_SLTIU:  begin r.wv = {31'd0, a_i < imm_i}; r.we = 1'b1; end
      OP_XORI:   begin r.wv = a_i ^ imm_i; r.we = 1'b1; end
      OP_ORI:    begin r.wv = a_i | imm_i; r.we = 1'b1; end
      OP_ANDI:   begin r.wv = a_i & imm_i; r.we = 1'b1; end
      OP_SLLI:   begin r.wv = a_i << imm_i[4:0]; r.we = 1'b1; end
      OP_SRLI:   begin r.wv = a_i >> imm_i[4:0]; r.we = 1'b1; end
      OP_SRAI:   begin r.wv = 32'($signed(a_i) >>> imm_i[4:0]); r.we = 1'b1; end
      OP_LB, OP_LBU: begin r.load = 1'b1; r.nbytes = 3'd1; end
      OP_LH, OP_LHU: begin r.load = 1'b1; r.nbytes = 3'd2; end
      OP_LW:     begin r.load = 1'b1; r.nbytes = 3'd4; end
      OP_BEQ:    take = (a_i == b_i);
      OP_BNE:    take = (a_i != b_i);
      OP_BLT:    take = ($signed(a_i) < $signed(b_i));
      OP_BGE:    take = !($signed(a_i) < $signed(b_i));
      OP_BLTU:   take = (a_i < b_i);
      OP_BGEU:   take = (a_i >= b_i);
      OP_SB:     begin r.store = 1'b1; r.nbytes = 3'd1; end
      OP_SH:     begin r.store = 1'b1; r.nbytes = 3'd2; end
      OP_SW:     begin r.store = 1'b1; r.nbytes = 3'd4; end
      OP_ADD:    begin r.wv = a_i + b_i; r.we = 1'b1; end
      OP_SUB:    begin r.wv = a_i - b_i; r.we = 1'b1; end
      OP_SLL:    begin r.wv = a_i << b_i[4:0]; r.we = 1'b1; end
      OP_SLT:    begin r.wv = {31'd0, $signed(a_i) < $signed(b_i)}; r.we = 1'b1; end
      OP_SLTU:   begin r.wv = {31'd0, a_i < b_i}; r.we = 1'b1; end
      OP_XOR:    begin r.wv = a_i ^ b_i; r.we = 1'b1; end
      OP_SRL:    begin r.wv = a_i >> b_i[4:0]; r.we = 1'b1; end
      OP_SRA:    begin r.wv = 32'($signed(a_i) >>> b_i[4:0]); r.we = 1'b1; end
      OP_OR:     begin r.wv = a_i | b_i; r.we = 1'b1; end
      OP_AND:    begin r.wv = a_i & b_i; r.we = 1'b1; end
      OP_FENCE, OP_ECALL, OP_EBREAK: begin r.halt = 1'b1; r.npc = pc_i; end
      default:   ;
    endcase
    // branches and jal scale the offset by one word
    if (take) begin
      r.npc = pc_i + (imm_i << 2);
    end
  end

  assign res_o = r;

endmodule

// ===== dv/tb_rv32i_instruction_execute_unit.sv =====
// ---------------------------------------------------------------------------
// RV32I execute unit testbench
// Drives decoded instructions through the valid/stall input channel and
// checks every result word against a cycle-free model of the register file,
// pc, byte data memory and halt flag. Both channels idle at random.
// ---------------------------------------------------------------------------
module tb_rv32i_instruction_execute_unit;
  import rvex_pkg::*;

  localparam int MemBytes  = 4096;
  localparam int NumRandom = 1300;
  localparam int CycleCap  = 300000;

  typedef struct {
    logic [5:0]         mode;
    logic [4:0]         rd;
    logic [4:0]         rs1;
    logic [4:0]         rs2;
    logic signed [20:0] imm;
    bit                 drain;
  } instr_t;

  typedef struct {
    logic [31:0] npc;
    logic        we;
    logic [4:0]  wreg;
    logic [31:0] wval;
    logic        halt;
  } retire_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [5:0] mode_i = '0;
  logic [4:0] dest_reg_i = '0;
  logic [4:0] src_reg_a_i = '0;
  logic [4:0] src_reg_b_i = '0;
  logic signed [20:0] imm_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [31:0] next_pc_o;
  logic write_enable_o;
  logic [4:0] write_reg_o;
  logic [31:0] write_value_o;
  logic halted_o;

  rv32i_instruction_execute_unit #(.MEM_BYTES(MemBytes)) dut (.*);

  always #5 clk_i = ~clk_i;

  // Architectural state of the model
  logic [31:0] arch_regs [32];
  logic [31:0] arch_pc;
  logic [7:0]  arch_mem [MemBytes];
  logic        arch_halt;

  instr_t  pending_instrs[$];
  retire_t expected_retires[$];
  int      error_count = 0;
  int      cycle_count = 0;

  function automatic logic [31:0] load_bytes(logic [31:0] addr, int n);
    logic [31:0] v;
    logic [31:0] ea;
    v = '0;
    for (int i = 0; i < n; i++) begin
      ea = addr + i;
      v |= 32'(arch_mem[ea % MemBytes]) << (8 * i);
    end
    return v;
  endfunction

  function automatic void store_bytes(logic [31:0] addr, logic [31:0] v, int n);
    logic [31:0] ea;
    for (int i = 0; i < n; i++) begin
      ea = addr + i;
      arch_mem[ea % MemBytes] = v[8*i +: 8];
    end
  endfunction

  // Execute one instruction against the model state
  function automatic retire_t execute_instr(instr_t ins);
    retire_t r;
    logic [31:0] a, b, imm, npc, wv, addr, ld;
    logic we, take;
    a = (ins.rs1 == 0) ? '0 : arch_regs[ins.rs1];
    b = (ins.rs2 == 0) ? '0 : arch_regs[ins.rs2];
    imm = {{11{ins.imm[20]}}, ins.imm};
    addr = a + imm;
    npc = arch_pc + 32'd4;
    wv = '0;
    ld = '0;
    we = 1'b0;
    take = 1'b0;
    if (arch_halt) begin
      r = '{arch_pc, 1'b0, 5'd0, 32'd0, 1'b1};
      return r;
    end
    case (ins.mode)
      OP_LUI:   begin wv = imm << 12; we = 1; end
      OP_AUIPC: begin wv = (imm << 12) + arch_pc; we = 1; end
      OP_JAL:   begin wv = arch_pc + 4; we = 1; npc = arch_pc + (imm << 2); end
      OP_JALR:  begin wv = arch_pc + 4; we = 1; npc = (a + imm) & ~32'd1; end
      OP_ADDI:  begin wv = a + imm; we = 1; end
      OP_SLTI:  begin wv = 32'($signed(a) < $signed(imm)); we = 1; end
      OP_SLTIU: begin wv = 32'(a < imm); we = 1; end
      OP_XORI:  begin wv = a ^ imm; we = 1; end
      OP_ORI:   begin wv = a | imm; we = 1; end
      OP_ANDI:  begin wv = a & imm; we = 1; end
      OP_SLLI:  begin wv = a << imm[4:0]; we = 1; end
      OP_SRLI:  begin wv = a >> imm[4:0]; we = 1; end
      OP_SRAI:  begin wv = $signed(a) >>> imm[4:0]; we = 1; end
      OP_LB:    begin ld = load_bytes(addr, 1); wv = {{24{ld[7]}}, ld[7:0]}; we = 1; end
      OP_LH:    begin ld = load_bytes(addr, 2); wv = {{16{ld[15]}}, ld[15:0]}; we = 1; end
      OP_LW:    begin wv = load_bytes(addr, 4); we = 1; end
      OP_LBU:   begin wv = load_bytes(addr, 1); we = 1; end
      OP_LHU:   begin wv = load_bytes(addr, 2); we = 1; end
      OP_BEQ:   take = (a == b);
      OP_BNE:   take = (a != b);
      OP_BLT:   take = ($signed(a) < $signed(b));
      OP_BGE:   take = ($signed(a) >= $signed(b));
      OP_BLTU:  take = (a < b);
      OP_BGEU:  take = (a >= b);
      OP_SB:    store_bytes(addr, b, 1);
      OP_SH:    store_bytes(addr, b, 2);
      OP_SW:    store_bytes(addr, b, 4);
      OP_ADD:   begin wv = a + b; we = 1; end
      OP_SUB:   begin wv = a - b; we = 1; end
      OP_SLL:   begin wv = a << b[4:0]; we = 1; end
      OP_SLT:   begin wv = 32'($signed(a) < $signed(b)); we = 1; end
      OP_SLTU:  begin wv = 32'(a < b); we = 1; end
      OP_XOR:   begin wv = a ^ b; we = 1; end
      OP_SRL:   begin wv = a >> b[4:0]; we = 1; end
      OP_SRA:   begin wv = $signed(a) >>> b[4:0]; we = 1; end
      OP_OR:    begin wv = a | b; we = 1; end
      OP_AND:   begin wv = a & b; we = 1; end
      OP_FENCE, OP_ECALL, OP_EBREAK: begin arch_halt = 1; npc = arch_pc; end
      default: ;
    endcase
    if (take) npc = arch_pc + (imm << 2);
    if (we && ins.rd != 0) begin
      arch_regs[ins.rd] = wv;
    end else begin
      we = 0;
      wv = '0;
    end
    arch_pc = npc;
    r = '{npc, we, (we ? ins.rd : 5'd0), wv, arch_halt};
    return r;
  endfunction

  function automatic instr_t mk(op_e op, int rd, int rs1, int rs2, int imm,
                                bit drain = 0);
    instr_t i;
    i = '{6'(op), 5'(rd), 5'(rs1), 5'(rs2), 21'(imm), drain};
    return i;
  endfunction

  // Random instruction: mostly real operations, some unused codes
  function automatic instr_t random_instr();
    instr_t i;
    int sel;
    sel = $urandom_range(99);
    i.mode = (sel < 6) ? 6'($urandom_range(63, 40)) : 6'($urandom_range(36, 0));
    i.rd = 5'($urandom);
    i.rs1 = 5'($urandom);
    i.rs2 = 5'($urandom);
    i.drain = 0;
    case ($urandom_range(3))
      0: i.imm = 21'($urandom);
      1: i.imm = 21'($signed($urandom_range(64)) - 32);
      default: i.imm = 21'($urandom_range(255));
    endcase
    // keep memory traffic near address zero so loads find stored data
    if (i.mode inside {[OP_LB:OP_LHU], [OP_SB:OP_SW]} && $urandom_range(1)) begin
      i.rs1 = '0;
      i.imm = 21'($urandom_range(127));
    end
    return i;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Sender: bursts and gaps, with an optional drain before some words
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    instr_t nxt;
    logic   drive;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      drive = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expected_retires.push_back(execute_instr(pending_instrs.pop_front()));
        drive = 1'b0;
      end
      if (!drive) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_instrs.size() > 0 &&
                     !(pending_instrs[0].drain && expected_retires.size() > 0)) begin
          nxt = pending_instrs[0];
          mode_i <= nxt.mode;
          dest_reg_i <= nxt.rd;
          src_reg_a_i <= nxt.rs1;
          src_reg_b_i <= nxt.rs2;
          imm_value_i <= nxt.imm;
          drive = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(30, 1);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
          end
        end
      end
      in_valid_i <= drive;
    end
  end

  // Receiver: stalls follow a randomly chosen pattern: none, random or periodic
  int stall_mode = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 64 == 0) stall_mode = $urandom_range(2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(2) == 0);
      default: out_stall_i <= (cycle_count % 11) < 6;
    endcase
    if (cycle_count >= CycleCap) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Check each accepted result word against the oldest expectation
  always @(posedge clk_i) begin
    retire_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_retires.size() == 0) begin
        report_mismatch("unexpected word", next_pc_o, 32'd0);
      end else begin
        w = expected_retires.pop_front();
        if (next_pc_o !== w.npc) report_mismatch("next_pc", next_pc_o, w.npc);
        if (write_enable_o !== w.we) report_mismatch("write_enable", 32'(write_enable_o), 32'(w.we));
        if (write_reg_o !== w.wreg) report_mismatch("write_reg", 32'(write_reg_o), 32'(w.wreg));
        if (write_value_o !== w.wval) report_mismatch("write_value", write_value_o, w.wval);
        if (halted_o !== w.halt) report_mismatch("halted", 32'(halted_o), 32'(w.halt));
      end
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    for (int i = 0; i < MemBytes; i++) arch_mem[i] = '0;
    arch_pc = '0;
    arch_halt = 1'b0;

    // Directed: field extremes, x0 writes, shift masking, wrapping addresses
    pending_instrs.push_back(mk(OP_LUI, 1, 0, 0, -1048576));
    pending_instrs.push_back(mk(OP_LUI, 0, 31, 31, 1048575));
    pending_instrs.push_back(mk(OP_ADDI, 2, 0, 0, 1048575));
    pending_instrs.push_back(mk(OP_ADDI, 3, 0, 0, -1));
    pending_instrs.push_back(mk(OP_AUIPC, 31, 0, 0, 1));
    pending_instrs.push_back(mk(OP_SLLI, 4, 3, 0, 63));
    pending_instrs.push_back(mk(OP_SRAI, 5, 1, 0, -1));
    pending_instrs.push_back(mk(OP_SRL, 6, 3, 2, 0));
    pending_instrs.push_back(mk(OP_SW, 0, 0, 1, -2));
    pending_instrs.push_back(mk(OP_LH, 7, 0, 0, -1));
    pending_instrs.push_back(mk(OP_LBU, 8, 0, 0, 1));
    pending_instrs.push_back(mk(OP_SB, 0, 3, 3, 4));
    pending_instrs.push_back(mk(OP_LW, 9, 0, 0, 0, 1));
    pending_instrs.push_back(mk(OP_BGEU, 0, 3, 2, 1048575));
    pending_instrs.push_back(mk(OP_BLT, 0, 1, 2, -1048576));
    pending_instrs.push_back(mk(OP_JALR, 10, 3, 0, 0));
    pending_instrs.push_back(mk(OP_JALR, 10, 10, 0, 1));
    pending_instrs.push_back(mk(OP_JAL, 0, 0, 0, -1048576));
    pending_instrs.push_back(mk(op_e'(6'd63), 31, 31, 31, 0));
    pending_instrs.push_back(mk(op_e'(6'd40), 1, 1, 1, -1));

    // Random: mostly live instructions, one drain in the middle
    for (int n = 0; n < NumRandom; n++) begin
      pending_instrs.push_back(random_instr());
      if (n == NumRandom / 2) pending_instrs[$].drain = 1;
    end

    // Stop, then words that the halted unit ignores
    pending_instrs.push_back(mk(OP_FENCE, 0, 0, 0, 0, 1));
    pending_instrs.push_back(mk(OP_ECALL, 0, 0, 0, 0));
    pending_instrs.push_back(mk(OP_EBREAK, 0, 0, 0, 0));
    pending_instrs.push_back(mk(OP_ADDI, 5, 3, 0, 7));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain, then allow for the tail latency
    do @(posedge clk_i);
    while (pending_instrs.size() > 0 || in_valid_i || expected_retires.size() > 0);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
